// ----- rtl/core/fuzzy_text_match_scorer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fuzzy text match scorer
// Concurrent checks sampled on the rising clock edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef FUZZY_TEXT_MATCH_SCORER_MACROS_SVH
`define FUZZY_TEXT_MATCH_SCORER_MACROS_SVH

// Condition that must hold at every edge.
`define FTMS_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define FTMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FTMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ftms_pkg.sv -----
// ----------------------------------------------------------------------------
// ftms_pkg
// Shared types and constants of the fuzzy text match scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package ftms_pkg;

    localparam int QRY_BYTES           = 16;
    localparam int QLEN_W              = $clog2(QRY_BYTES + 1);
    localparam int DEF_MAX_QUERY_BYTES = 16;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 64;
    localparam int SCORE_W             = 10;

    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QRY_LOW  = 2'd0,
        CFG_QRY_HIGH = 2'd1,
        CFG_QRY_LEN  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_EXACT    = 3'd1,
        KIND_PREFIX   = 3'd2,
        KIND_WORD     = 3'd3,
        KIND_INITIALS = 3'd4,
        KIND_SUBSTR   = 3'd5,
        KIND_SCATTER  = 3'd6
    } t_kind;

    // Trimmed query as seen by the trackers.
    // nxt[k]: index of the next non-space byte after k, or len if none.
    typedef struct packed {
        logic [QLEN_W-1:0]                 len;
        logic [QRY_BYTES-1:0][7:0]         bytes;
        logic [QRY_BYTES-1:0][QLEN_W-1:0]  nxt;
    } t_qry;

endpackage

`default_nettype wire

// ----- rtl/core/ftms_query.sv -----
// ----------------------------------------------------------------------------
// ftms_query
// Query registers plus the trimmed copy and next-non-space table.
// ----------------------------------------------------------------------------
`default_nettype none

module ftms_query import ftms_pkg::*; #(
    parameter int MAX_QUERY_BYTES = DEF_MAX_QUERY_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_qry                  o_qry
);

    localparam int QCAP = (MAX_QUERY_BYTES < QRY_BYTES) ? MAX_QUERY_BYTES : QRY_BYTES;

    logic [CFG_DATA_W-1:0]    r_qry_lo, n_qry_lo;
    logic [CFG_DATA_W-1:0]    r_qry_hi, n_qry_hi;
    logic [QLEN_W-1:0]        r_qry_len, n_qry_len;
    t_qry                     r_qry, n_qry;

    logic [8*QRY_BYTES-1:0]   raw;
    logic [8*QRY_BYTES-1:0]   shifted;
    logic [QLEN_W-1:0]        len_c;
    logic [QRY_BYTES-1:0]     ns;
    logic [QRY_BYTES-1:0]     nsq;
    logic [QRY_BYTES-1:0]     above;
    logic [3:0]               first_ns;
    logic [3:0]               last_ns;
    logic [QLEN_W-1:0]        nxt_idx;

    // Register writes; the derived query follows the written values directly.
    always_comb begin
        n_qry_lo  = r_qry_lo;
        n_qry_hi  = r_qry_hi;
        n_qry_len = r_qry_len;
        if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_QRY_LOW:  n_qry_lo  = i_cfg_data;
                CFG_QRY_HIGH: n_qry_hi  = i_cfg_data;
                CFG_QRY_LEN:  n_qry_len = i_cfg_data[QLEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Trim leading and trailing spaces.
    always_comb begin
        raw   = {n_qry_hi, n_qry_lo};
        len_c = (n_qry_len > QLEN_W'(QCAP)) ? QLEN_W'(QCAP) : n_qry_len;
        for (int k = 0; k < QRY_BYTES; k++) begin
            ns[k] = (raw[8*k +: 8] != CH_SPACE) && (QLEN_W'(k) < len_c);
        end
        first_ns = '0;
        for (int k = QRY_BYTES - 1; k >= 0; k--) begin
            if (ns[k]) first_ns = 4'(k);
        end
        last_ns = '0;
        for (int k = 0; k < QRY_BYTES; k++) begin
            if (ns[k]) last_ns = 4'(k);
        end
        shifted = raw >> {first_ns, 3'b000};
        nsq     = ns >> first_ns;

        n_qry.len = (|ns) ? (QLEN_W'(last_ns) - QLEN_W'(first_ns) + QLEN_W'(1)) : '0;
        for (int k = 0; k < QRY_BYTES; k++) begin
            n_qry.bytes[k] = shifted[8*k +: 8];
        end

        // Next non-space byte after each position.
        for (int k = 0; k < QRY_BYTES; k++) begin
            above   = nsq & (16'hFFFF << (k + 1));
            nxt_idx = n_qry.len;
            for (int j = QRY_BYTES - 1; j >= 0; j--) begin
                if (above[j]) nxt_idx = QLEN_W'(j);
            end
            n_qry.nxt[k] = nxt_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qry_lo  <= '0;
            r_qry_hi  <= '0;
            r_qry_len <= '0;
            r_qry     <= '0;
        end else begin
            r_qry_lo  <= n_qry_lo;
            r_qry_hi  <= n_qry_hi;
            r_qry_len <= n_qry_len;
            r_qry     <= n_qry;
        end
    end

    assign o_qry = r_qry;

endmodule

`default_nettype wire

// ----- rtl/core/ftms_track.sv -----
// ----------------------------------------------------------------------------
// ftms_track
// Per-text match trackers and the score selection at the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ftms_track import ftms_pkg::*; #(
    parameter int MAX_QUERY_BYTES = DEF_MAX_QUERY_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic               i_empty,
    input  t_qry               i_qry,
    output logic [SCORE_W-1:0] o_score,
    output t_kind              o_kind
);

`include "fuzzy_text_match_scorer_macros.svh"

    localparam int QW = (MAX_QUERY_BYTES < QRY_BYTES) ? MAX_QUERY_BYTES : QRY_BYTES;

    localparam logic [SCORE_W-1:0] SC_EXACT    = 10'd1000;
    localparam logic [SCORE_W-1:0] SC_PREFIX   = 10'd800;
    localparam logic [SCORE_W-1:0] SC_WORD     = 10'd600;
    localparam logic [SCORE_W-1:0] SC_INITIALS = 10'd500;
    localparam logic [SCORE_W-1:0] SC_SUBSTR   = 10'd400;
    localparam logic [SCORE_W-1:0] SC_SCATTER  = 10'd200;
    localparam logic [7:0]         CAP_POS     = 8'd100;
    localparam logic [3:0]         GAP_SAT     = 4'd11;
    localparam logic [3:0]         GAP_KEEP    = 4'd10;

    logic [7:0]        r_pos, n_pos;
    logic              r_pfx, n_pfx;
    logic              r_prev_sep, n_prev_sep;
    logic [QW-1:0]     r_wv, n_wv;
    logic              r_wsh, n_wsh;
    logic [QW-1:0]     r_sv, n_sv;
    logic              r_sub_hit, n_sub_hit;
    logic [6:0]        r_sub_off, n_sub_off;
    logic [QLEN_W-1:0] r_ic, n_ic;
    logic              r_ism, n_ism;
    logic [QLEN_W-1:0] r_ptr, n_ptr;
    logic [3:0]        r_gap_run, n_gap_run;
    logic [3:0]        r_gap_tot, n_gap_tot;

    logic [QW-1:0]     eq, full, sv, wv;
    logic              c_sep, wstart, clear_all;
    logic [8:0]        sub_start;
    logic [4:0]        gap_sum;
    logic [7:0]        qlen8, extra;
    logic [6:0]        extra_cap;

    function automatic logic is_sep(input logic [7:0] c);
        // space - _ . : /
        return c inside {8'h20, 8'h2D, 8'h5F, 8'h2E, 8'h3A, 8'h2F};
    endfunction

    always_comb begin
        n_pos      = r_pos;
        n_pfx      = r_pfx;
        n_prev_sep = r_prev_sep;
        n_wv       = r_wv;
        n_wsh      = r_wsh;
        n_sv       = r_sv;
        n_sub_hit  = r_sub_hit;
        n_sub_off  = r_sub_off;
        n_ic       = r_ic;
        n_ism      = r_ism;
        n_ptr      = r_ptr;
        n_gap_run  = r_gap_run;
        n_gap_tot  = r_gap_tot;
        o_score    = '0;
        o_kind     = KIND_NONE;
        clear_all  = 1'b0;

        qlen8  = 8'(i_qry.len);
        c_sep  = is_sep(i_byte);
        wstart = !c_sep && r_prev_sep;
        for (int k = 0; k < QW; k++) begin
            eq[k]   = (i_byte == i_qry.bytes[k]) && (QLEN_W'(k) < i_qry.len);
            full[k] = (i_qry.len == QLEN_W'(k + 1));
        end
        // Shift-and match vectors: bit k set when query[0..k] ends here.
        sv[0] = eq[0];
        wv[0] = eq[0] && wstart;
        for (int k = 1; k < QW; k++) begin
            sv[k] = eq[k] && r_sv[k-1];
            wv[k] = eq[k] && r_wv[k-1];
        end
        sub_start = 9'(r_pos) + 9'd1 - 9'(i_qry.len);
        gap_sum   = 5'(r_gap_tot) + 5'(r_gap_run);
        extra     = '0;
        extra_cap = '0;

        if (i_empty) begin
            clear_all = 1'b1;
        end else begin
            if ((r_pos < qlen8) && (i_byte != i_qry.bytes[r_pos[3:0]])) begin
                n_pfx = 1'b0;
            end
            n_sv = sv;
            n_wv = wv;
            if ((|(sv & full)) && !r_sub_hit) begin
                n_sub_hit = 1'b1;
                n_sub_off = (sub_start > 9'(CAP_POS)) ? CAP_POS[6:0] : sub_start[6:0];
            end
            if (|(wv & full)) begin
                n_wsh = 1'b1;
            end
            if (wstart && (r_ic < i_qry.len)) begin
                if (i_byte != i_qry.bytes[r_ic[3:0]]) n_ism = 1'b0;
                n_ic = r_ic + QLEN_W'(1);
            end
            n_prev_sep = c_sep;

            // Greedy in-order letters, spaces in the query skipped via nxt.
            if (r_ptr < i_qry.len) begin
                if (i_byte == i_qry.bytes[r_ptr[3:0]]) begin
                    if (r_ptr != '0) begin
                        n_gap_tot = (gap_sum > 5'(GAP_SAT)) ? GAP_SAT : gap_sum[3:0];
                    end
                    n_gap_run = '0;
                    n_ptr     = i_qry.nxt[r_ptr[3:0]];
                end else if ((r_ptr != '0) && (r_gap_run != 4'hF)) begin
                    n_gap_run = r_gap_run + 4'd1;
                end
            end

            if (r_pos != 8'hFF) n_pos = r_pos + 8'd1;

            if (i_last) begin
                clear_all = 1'b1;
                extra     = n_pos - qlen8;
                extra_cap = (extra > CAP_POS) ? CAP_POS[6:0] : extra[6:0];
                if (i_qry.len != '0) begin
                    if (n_pfx && (n_pos == qlen8)) begin
                        o_score = SC_EXACT;
                        o_kind  = KIND_EXACT;
                    end else if (n_pfx && (n_pos > qlen8)) begin
                        o_score = SC_PREFIX - 10'(extra_cap);
                        o_kind  = KIND_PREFIX;
                    end else if (n_wsh) begin
                        o_score = SC_WORD;
                        o_kind  = KIND_WORD;
                    end else if ((i_qry.len > QLEN_W'(1)) && n_ism && (n_ic >= i_qry.len)) begin
                        o_score = SC_INITIALS;
                        o_kind  = KIND_INITIALS;
                    end else if (n_sub_hit) begin
                        o_score = SC_SUBSTR - 10'(n_sub_off);
                        o_kind  = KIND_SUBSTR;
                    end else if ((n_ptr == i_qry.len) && (n_gap_tot <= GAP_KEEP)) begin
                        o_score = SC_SCATTER - {3'b000, n_gap_tot, 3'b000};
                        o_kind  = KIND_SCATTER;
                    end
                end
            end
        end

        if (clear_all) begin
            n_pos      = '0;
            n_pfx      = 1'b1;
            n_prev_sep = 1'b1;
            n_wv       = '0;
            n_wsh      = 1'b0;
            n_sv       = '0;
            n_sub_hit  = 1'b0;
            n_sub_off  = '0;
            n_ic       = '0;
            n_ism      = 1'b1;
            n_ptr      = '0;
            n_gap_run  = '0;
            n_gap_tot  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_pfx      <= 1'b1;
            r_prev_sep <= 1'b1;
            r_wv       <= '0;
            r_wsh      <= 1'b0;
            r_sv       <= '0;
            r_sub_hit  <= 1'b0;
            r_sub_off  <= '0;
            r_ic       <= '0;
            r_ism      <= 1'b1;
            r_ptr      <= '0;
            r_gap_run  <= '0;
            r_gap_tot  <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_pfx      <= n_pfx;
            r_prev_sep <= n_prev_sep;
            r_wv       <= n_wv;
            r_wsh      <= n_wsh;
            r_sv       <= n_sv;
            r_sub_hit  <= n_sub_hit;
            r_sub_off  <= n_sub_off;
            r_ic       <= n_ic;
            r_ism      <= n_ism;
            r_ptr      <= n_ptr;
            r_gap_run  <= n_gap_run;
            r_gap_tot  <= n_gap_tot;
        end
    end

    `FTMS_ASSERT_ALWAYS(a_gap_tot_sat, i_clk, i_rst_n, r_gap_tot <= GAP_SAT, "gap total above saturation")
    `FTMS_ASSERT_ALWAYS(a_sub_off_cap, i_clk, i_rst_n, r_sub_off <= CAP_POS[6:0], "substring offset above cap")
    `FTMS_ASSERT_ALWAYS(a_init_cnt, i_clk, i_rst_n, r_ic <= QLEN_W'(QRY_BYTES), "initials count overran query")
    `FTMS_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_step && (i_last || i_empty), (r_pos == '0) && r_pfx && (r_ptr == '0), "trackers not cleared after text end")

endmodule

`default_nettype wire

// ----- rtl/core/fuzzy_text_match_scorer.sv -----
// ----------------------------------------------------------------------------
// fuzzy_text_match_scorer
// A byte waits in the input register until the trackers take it; a byte
// with last or empty set has its result stored in the result register.
// Throughput: one text byte per cycle from the input register and tracker
// update, while no result byte waits on a stalled result; a stalled result
// does not stop bytes that give no result. Synchronous active-low reset
// zeroes the query registers and returns every tracker to a text's start.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_text_match_scorer import ftms_pkg::*; #(
    parameter int MAX_QUERY_BYTES = DEF_MAX_QUERY_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // text byte channel
    input  logic                  i_text_valid,
    output logic                  o_text_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_text_last,
    input  logic                  i_text_empty,
    // result channel
    output logic                  o_score_valid,
    input  logic                  i_score_stall,
    output logic [SCORE_W-1:0]    o_match_score,
    output logic [2:0]            o_match_kind,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "fuzzy_text_match_scorer_macros.svh"

    // Input register: holds one byte until the trackers take it.
    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_in_empty;

    // Result register: parts the result side from the byte side.
    logic                r_out_vld;
    logic [SCORE_W-1:0]  r_out_score;
    t_kind               r_out_kind;

    logic                in_xfer;
    logic                in_res;
    logic                out_free;
    logic                adv;
    logic [SCORE_W-1:0]  trk_score;
    t_kind               trk_kind;
    t_qry                qry;

    // Registers are always writable; the query copy settles at the write edge.
    assign o_cfg_ready = 1'b1;

    ftms_query #(
        .MAX_QUERY_BYTES (MAX_QUERY_BYTES)
    ) u_query (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_qry       (qry)
    );

    // A byte with last or empty set yields a result and needs room in the
    // result register; any other byte always moves on.
    assign in_res       = r_in_last || r_in_empty;
    assign out_free     = !r_out_vld || !i_score_stall;
    assign adv          = r_in_vld && (!in_res || out_free);
    assign o_text_stall = r_in_vld && !adv;
    assign in_xfer      = i_text_valid && !o_text_stall;

    ftms_track #(
        .MAX_QUERY_BYTES (MAX_QUERY_BYTES)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_empty (r_in_empty),
        .i_qry   (qry),
        .o_score (trk_score),
        .o_kind  (trk_kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_xfer || (r_in_vld && !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte  <= i_text_byte;
            r_in_last  <= i_text_last;
            r_in_empty <= i_text_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && in_res) begin
            r_out_vld <= 1'b1;
        end else if (!i_score_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && in_res) begin
            r_out_score <= trk_score;
            r_out_kind  <= trk_kind;
        end
    end

    assign o_score_valid = r_out_vld;
    assign o_match_score = r_out_score;
    assign o_match_kind  = r_out_kind;

    // A waiting byte is neither lost nor altered while the trackers hold off.
    `FTMS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, o_text_stall, r_in_vld && $stable(r_in_byte) && $stable(r_in_last) && $stable(r_in_empty), "waiting byte lost")
    // A stalled result is not dropped by the result register.
    `FTMS_ASSERT_NEXT(a_out_keep, i_clk, i_rst_n, r_out_vld && i_score_stall, r_out_vld, "stalled result dropped")
    // Kind none goes with score zero and only with it.
    `FTMS_ASSERT_IMPL(a_kind_score, i_clk, i_rst_n, r_out_vld, (r_out_kind == KIND_NONE) == (r_out_score == '0), "kind and score disagree")
    // An exact match always carries the top score.
    `FTMS_ASSERT_IMPL(a_exact_top, i_clk, i_rst_n, r_out_vld && (r_out_kind == KIND_EXACT), r_out_score == 10'd1000, "exact match without top score")

endmodule

`default_nettype wire
